// ----- rtl/core/stt_pkg.sv -----
// Shared types, codes and constants of the software timer table.
`default_nettype none

package stt_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIME_W         = 48;
    localparam int TMO_W          = 32;
    localparam int TASK_W         = 8;
    localparam int EVENT_W        = 16;
    localparam int COUNT_W        = 5;
    localparam int COUNT_MAX      = 31;

    // a tick fires at most this many timers
    localparam int MAX_FIRE       = 16;
    localparam int FIRE_CNT_W     = $clog2(MAX_FIRE + 1);
    localparam int FIRE_IDX_W     = $clog2(MAX_FIRE);

    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_QUERY = 2'd2,
        OP_TICK  = 2'd3
    } stt_op_e;

    typedef enum logic [2:0] {
        ST_ADDED      = 3'd0,
        ST_REARMED    = 3'd1,
        ST_NOT_FOUND  = 3'd2,
        ST_FULL       = 3'd3,
        ST_FIRED      = 3'd4,
        ST_NONE_FIRED = 3'd5
    } stt_status_e;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DECIDE,
        BK_FIRE_RD,
        BK_FIRE_WAIT
    } stt_state_e;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [TASK_W-1:0]  task_id;
        logic [EVENT_W-1:0] evt_flag;
        logic [TMO_W-1:0]   timeout_ms;
        logic [TIME_W-1:0]  now_ms;
    } stt_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [TIME_W-1:0]  deadline_ms;
        logic [TASK_W-1:0]  fired_task;
        logic [EVENT_W-1:0] fired_event;
        logic [COUNT_W-1:0] active_count;
        logic               last;
    } stt_out_t;

    // classified command: tval is the armed deadline for start, now for tick
    typedef struct packed {
        stt_op_e            op;
        logic [TASK_W-1:0]  task_id;
        logic [EVENT_W-1:0] evt_flag;
        logic [TIME_W-1:0]  tval;
    } stt_cmd_t;

    typedef struct packed {
        logic [TASK_W-1:0]  task_id;
        logic [EVENT_W-1:0] evt_flag;
        logic [TIME_W-1:0]  deadline_ms;
    } stt_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/stt_if.sv -----
// Valid/ready stream interfaces for the input and result channels.
`default_nettype none

interface stt_in_if
    import stt_pkg::*;
;
    logic    valid;
    logic    ready;
    stt_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stt_out_if
    import stt_pkg::*;
;
    logic     valid;
    logic     ready;
    stt_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/software_timer_table.sv -----
// Software timer table: one-shot timers keyed by task and event flag.
//
// Channels: cmd carries input transactions (opcode, task_id, evt_flag,
// timeout_ms, now_ms); result carries result transactions (status,
// deadline_ms, fired_task, fired_event, active_count, last). Both are
// valid/ready; a transaction moves when valid and ready are both high.
// Start, stop and query give one result; a tick gives one result per fired
// timer (lowest slots first, at most 16) or one none-fired result.
// Every operation scans all slots through the timer memory, one slot per
// cycle; a tick then reads each fired timer back from the memory before
// its result. The engine takes no new command from the queue until its
// last result is registered.
// A two-entry command queue lets input transactions be taken while the
// engine is busy; cmd.ready drops when it is full.
// Reset clears all slot valid bits and the active count at once.
// A stalled result holds in the output register and the engine waits.
`default_nettype none

module software_timer_table
    import stt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    stt_in_if.sink    cmd,
    stt_out_if.source result
);

    logic     push_valid;
    logic     push_ready;
    stt_cmd_t push_data;
    logic     pop_valid;
    logic     pop_ready;
    stt_cmd_t pop_data;

    stt_front u_front (
        .cmd        (cmd),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    stt_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    stt_back #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .result     (result)
    );

endmodule

`default_nettype wire

// ----- rtl/core/stt_front.sv -----
// Front end: accepts input transactions, decodes them and computes armed deadlines.
`default_nettype none

module stt_front
    import stt_pkg::*;
(
    stt_in_if.sink          cmd,
    output logic            push_valid,
    input  logic            push_ready,
    output stt_cmd_t        push_data
);

    logic [TIME_W:0]   dl_sum;
    logic [TIME_W-1:0] dl_sat;

    assign dl_sum = {1'b0, cmd.data.now_ms} + (TIME_W + 1)'(cmd.data.timeout_ms);
    assign dl_sat = dl_sum[TIME_W] ? {TIME_W{1'b1}} : dl_sum[TIME_W-1:0];

    assign cmd.ready  = push_ready;
    assign push_valid = cmd.valid;

    always_comb
    begin
        push_data.task_id  = cmd.data.task_id;
        push_data.evt_flag = cmd.data.evt_flag;
        case (cmd.data.opcode)
            OP_START:
            begin
                push_data.op   = OP_START;
                push_data.tval = dl_sat;
            end
            OP_STOP:
            begin
                push_data.op   = OP_STOP;
                push_data.tval = cmd.data.now_ms;
            end
            OP_QUERY:
            begin
                push_data.op   = OP_QUERY;
                push_data.tval = cmd.data.now_ms;
            end
            default:
            begin
                push_data.op   = OP_TICK;
                push_data.tval = cmd.data.now_ms;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/stt_cmd_queue.sv -----
// Short command queue between the front end and the table engine.
`default_nettype none

module stt_cmd_queue
    import stt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  stt_cmd_t push_data,
    output logic     pop_valid,
    input  logic     pop_ready,
    output stt_cmd_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    stt_cmd_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/stt_back.sv -----
// Table engine: timer storage, slot scan sequencer and result register.
`default_nettype none

module stt_back
    import stt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      pop_valid,
    output logic      pop_ready,
    input  stt_cmd_t  pop_data,
    stt_out_if.source result
);

    localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int SCAN_W = $clog2(NUM_TIMERS + 1);
    localparam int CNT_W  = $clog2(NUM_TIMERS + 1);

    stt_state_e              state_reg, state_next;
    stt_cmd_t                cmd_reg, cmd_next;
    logic [NUM_TIMERS-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [SCAN_W-1:0]       scan_addr_reg, scan_addr_next;
    logic                    rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic                    found_reg, found_next;
    logic [IDX_W-1:0]        match_idx_reg, match_idx_next;
    logic [TIME_W-1:0]       match_dl_reg, match_dl_next;
    logic                    free_found_reg, free_found_next;
    logic [IDX_W-1:0]        free_idx_reg, free_idx_next;
    logic [FIRE_CNT_W-1:0]   fire_n_reg, fire_n_next;
    logic [FIRE_CNT_W-1:0]   fire_k_reg, fire_k_next;
    logic [IDX_W-1:0]        fire_idx_reg [MAX_FIRE];
    logic [IDX_W-1:0]        fire_idx_next [MAX_FIRE];
    logic                    res_valid_reg, res_valid_next;
    stt_out_t                res_data_reg, res_data_next;

    stt_entry_t              mem [NUM_TIMERS];
    stt_entry_t              rd_data_reg;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    stt_entry_t              wr_data;

    logic                    out_free;
    logic                    slot_v;
    logic [31:0]             count_ext;

    assign out_free     = !res_valid_reg || result.ready;
    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;
    assign pop_ready    = (state_reg == BK_IDLE);
    assign slot_v       = valid_reg[rd_idx_reg];

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        scan_addr_next  = scan_addr_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        match_idx_next  = match_idx_reg;
        match_dl_next   = match_dl_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        fire_n_next     = fire_n_reg;
        fire_k_next     = fire_k_reg;
        fire_idx_next   = fire_idx_reg;
        res_valid_next  = res_valid_reg && !result.ready;
        res_data_next   = res_data_reg;
        rd_en           = 1'b0;
        rd_addr         = scan_addr_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = found_reg ? match_idx_reg : free_idx_reg;
        wr_data.task_id     = cmd_reg.task_id;
        wr_data.evt_flag    = cmd_reg.evt_flag;
        wr_data.deadline_ms = cmd_reg.tval;
        count_ext       = '0;

        case (state_reg)
            BK_IDLE:
            begin
                if (pop_valid)
                begin
                    cmd_next        = pop_data;
                    scan_addr_next  = '0;
                    found_next      = 1'b0;
                    free_found_next = 1'b0;
                    fire_n_next     = '0;
                    fire_k_next     = '0;
                    state_next      = BK_SCAN;
                end
            end

            BK_SCAN:
            begin
                // read issue stage
                if (scan_addr_reg != SCAN_W'(NUM_TIMERS))
                begin
                    rd_en          = 1'b1;
                    rd_pend_next   = 1'b1;
                    rd_idx_next    = scan_addr_reg[IDX_W-1:0];
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                // evaluate stage, one slot behind the read
                if (rd_pend_reg)
                begin
                    if (cmd_reg.op == OP_TICK)
                    begin
                        if (slot_v && (rd_data_reg.evt_flag != '0) &&
                            (rd_data_reg.deadline_ms <= cmd_reg.tval) &&
                            (fire_n_reg != FIRE_CNT_W'(MAX_FIRE)))
                        begin
                            valid_next[rd_idx_reg] = 1'b0;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            fire_idx_next[fire_n_reg[FIRE_IDX_W-1:0]] = rd_idx_reg;
                            fire_n_next = fire_n_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (slot_v && !found_reg &&
                            (rd_data_reg.task_id == cmd_reg.task_id) &&
                            (rd_data_reg.evt_flag == cmd_reg.evt_flag))
                        begin
                            found_next     = 1'b1;
                            match_idx_next = rd_idx_reg;
                            match_dl_next  = rd_data_reg.deadline_ms;
                        end
                        if (!slot_v && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = rd_idx_reg;
                        end
                    end
                    if (rd_idx_reg == IDX_W'(NUM_TIMERS - 1))
                    begin
                        state_next = BK_DECIDE;
                    end
                end
            end

            BK_DECIDE:
            begin
                if ((cmd_reg.op == OP_TICK) && (fire_n_reg != '0))
                begin
                    state_next = BK_FIRE_RD;
                end
                else if (out_free)
                begin
                    res_data_next.deadline_ms = '0;
                    res_data_next.fired_task  = '0;
                    res_data_next.fired_event = '0;
                    res_data_next.last        = 1'b1;
                    case (cmd_reg.op)
                        OP_START:
                        begin
                            if (found_reg)
                            begin
                                wr_en = 1'b1;
                                res_data_next.status      = ST_REARMED;
                                res_data_next.deadline_ms = cmd_reg.tval;
                            end
                            else if (free_found_reg)
                            begin
                                wr_en = 1'b1;
                                valid_next[free_idx_reg] = 1'b1;
                                count_next = count_reg + 1'b1;
                                res_data_next.status      = ST_ADDED;
                                res_data_next.deadline_ms = cmd_reg.tval;
                            end
                            else
                            begin
                                res_data_next.status = ST_FULL;
                            end
                        end
                        OP_STOP, OP_QUERY:
                        begin
                            if (found_reg)
                            begin
                                if (cmd_reg.op == OP_STOP)
                                begin
                                    valid_next[match_idx_reg] = 1'b0;
                                    if (count_reg != '0)
                                    begin
                                        count_next = count_reg - 1'b1;
                                    end
                                end
                                res_data_next.status      = ST_ADDED;
                                res_data_next.deadline_ms = match_dl_reg;
                            end
                            else
                            begin
                                res_data_next.status = ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            res_data_next.status = ST_NONE_FIRED;
                        end
                    endcase
                    count_ext = 32'(count_next);
                    res_data_next.active_count = (count_ext > 32'(COUNT_MAX)) ?
                        COUNT_W'(COUNT_MAX) : count_ext[COUNT_W-1:0];
                    res_valid_next = 1'b1;
                    state_next     = BK_IDLE;
                end
            end

            BK_FIRE_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = fire_idx_reg[fire_k_reg[FIRE_IDX_W-1:0]];
                state_next = BK_FIRE_WAIT;
            end

            BK_FIRE_WAIT:
            begin
                if (out_free)
                begin
                    count_ext = 32'(count_reg);
                    res_data_next.status       = ST_FIRED;
                    res_data_next.deadline_ms  = rd_data_reg.deadline_ms;
                    res_data_next.fired_task   = rd_data_reg.task_id;
                    res_data_next.fired_event  = rd_data_reg.evt_flag;
                    res_data_next.active_count = (count_ext > 32'(COUNT_MAX)) ?
                        COUNT_W'(COUNT_MAX) : count_ext[COUNT_W-1:0];
                    res_data_next.last = (FIRE_CNT_W'(fire_k_reg + 1'b1) == fire_n_reg);
                    res_valid_next     = 1'b1;
                    fire_k_next        = fire_k_reg + 1'b1;
                    state_next = res_data_next.last ? BK_IDLE : BK_FIRE_RD;
                end
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            scan_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            found_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            fire_n_reg    <= '0;
            fire_k_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            scan_addr_reg <= scan_addr_next;
            rd_pend_reg   <= rd_pend_next;
            found_reg     <= found_next;
            free_found_reg <= free_found_next;
            fire_n_reg    <= fire_n_next;
            fire_k_reg    <= fire_k_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        rd_idx_reg    <= rd_idx_next;
        match_idx_reg <= match_idx_next;
        match_dl_reg  <= match_dl_next;
        free_idx_reg  <= free_idx_next;
        fire_idx_reg  <= fire_idx_next;
        res_data_reg  <= res_data_next;
    end

    // timer storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

`ifndef NO_ASSERTIONS
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("active count differs from number of valid slots");

    a_fire_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fire_n_reg <= FIRE_CNT_W'(MAX_FIRE))
        else $error("more firings recorded than allowed per tick");

    a_fire_wait_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_FIRE_WAIT) |-> (fire_k_reg < fire_n_reg))
        else $error("firing emission past recorded list");

    a_single_result_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_data_reg.status != ST_FIRED)) |-> res_data_reg.last)
        else $error("non-firing result without last");
`endif

endmodule

`default_nettype wire
